>>> hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, port kind codes and port count lookup for the stream switch
// connection check.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int unsigned SSC_QUEUE_DEPTH = 2;

	// port kinds
	localparam logic [3:0] K_CORE  = 4'd0;
	localparam logic [3:0] K_DMA   = 4'd1;
	localparam logic [3:0] K_CTRL  = 4'd2;
	localparam logic [3:0] K_FIFO  = 4'd3;
	localparam logic [3:0] K_SOUTH = 4'd4;
	localparam logic [3:0] K_WEST  = 4'd5;
	localparam logic [3:0] K_NORTH = 4'd6;
	localparam logic [3:0] K_EAST  = 4'd7;
	localparam logic [3:0] K_TRACE = 4'd8;

	// device generations
	localparam logic GEN_A = 1'b0;
	localparam logic GEN_B = 1'b1;

	localparam logic [5:0] LAST_COL_A = 6'd49;
	localparam logic [5:0] LAST_COL_B = 6'd37;
	localparam logic [3:0] LAST_ROW_A = 4'd8;
	localparam logic [3:0] LAST_ROW_B = 4'd10;

	typedef enum logic [1:0] {
		TILE_SHIM,
		TILE_MEM,
		TILE_CORE
	} tile_class_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        gen;
		tile_class_t cls;
		logic [3:0]  source_kind;
		logic [3:0]  source_channel;
		logic [3:0]  dest_kind;
		logic [3:0]  dest_channel;
		logic [3:0]  source_count;
		logic [3:0]  dest_count;
	} ssc_item_t;

	function automatic logic ssc_is_gateway(input logic gen, input logic [5:0] col);
		logic r;
		r = 1'b0;
		if (gen == GEN_B) begin
			r = col inside {6'd2, 6'd3, 6'd6, 6'd7, 6'd14, 6'd15,
				6'd22, 6'd23, 6'd30, 6'd31, 6'd34, 6'd35};
		end else begin
			r = col inside {6'd2, 6'd3, 6'd6, 6'd7, 6'd10, 6'd11, 6'd18, 6'd19,
				6'd26, 6'd27, 6'd34, 6'd35, 6'd42, 6'd43, 6'd46, 6'd47};
		end
		return r;
	endfunction

	function automatic logic [3:0] ssc_port_count(input logic gen, input logic src,
			input logic [5:0] col, input logic [3:0] row, input logic [3:0] kind);
		logic [3:0] west;
		logic [3:0] east;
		logic [3:0] r;
		logic [5:0] last_col;
		logic [3:0] last_row;
		last_col = (gen == GEN_B) ? LAST_COL_B : LAST_COL_A;
		last_row = (gen == GEN_B) ? LAST_ROW_B : LAST_ROW_A;
		west = (col == 6'd0) ? 4'd0 : 4'd4;
		east = (col == last_col) ? 4'd0 : 4'd4;
		r = 4'd0;
		if (gen == GEN_B && (row == 4'd1 || row == 4'd2)) begin
			case (kind)
				K_DMA:   r = 4'd6;
				K_NORTH: r = src ? 4'd4 : 4'd6;
				K_SOUTH: r = src ? 4'd6 : 4'd4;
				K_TRACE: r = src ? 4'd1 : 4'd0;
				K_CTRL:  r = 4'd1;
				default: r = 4'd0;
			endcase
		end else if (row == 4'd0) begin
			case (kind)
				K_FIFO:  r = (gen == GEN_B) ? 4'd1 : 4'd2;
				K_NORTH: r = src ? 4'd4 : 4'd6;
				K_WEST:  r = west;
				K_SOUTH: r = src ? 4'd8 : 4'd6;
				K_EAST:  r = east;
				K_TRACE: r = src ? 4'd1 : 4'd0;
				K_CTRL:  r = ssc_is_gateway(gen, col) ? 4'd1 : 4'd0;
				default: r = 4'd0;
			endcase
		end else begin
			case (kind)
				K_CORE:  r = (gen == GEN_B) ? 4'd1 : 4'd2;
				K_DMA:   r = 4'd2;
				K_FIFO:  r = (gen == GEN_B) ? 4'd1 : 4'd2;
				K_NORTH: r = (row == last_row) ? 4'd0 : (src ? 4'd4 : 4'd6);
				K_WEST:  r = west;
				K_SOUTH: r = src ? 4'd6 : 4'd4;
				K_EAST:  r = east;
				K_TRACE: r = src ? 4'd2 : 4'd0;
				K_CTRL:  r = 4'd1;
				default: r = 4'd0;
			endcase
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/stream_switch_connection_check.sv
// ----------------------------------------------------------------------------
// stream_switch_connection_check
// Checks whether a tile's stream switch may connect a source to a destination
// port and reports the port counts of both kinds.
// ----------------------------------------------------------------------------
// One query is taken every cycle while in_ready is high. Each item passes the
// front register (tile class and port count lookup), the queue, and the output
// register that applies the rules. With the output side stalled the block holds
// four items (output register, two queue entries, front register) before it
// holds off its input. device_select picks the array generation and may only
// be written while no query is in flight; a write completes in the cycle it is
// presented.
module stream_switch_connection_check import ssc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = SSC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       device_select,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [5:0] tile_column,
	input  logic [3:0] tile_row,
	input  logic [3:0] source_kind,
	input  logic [3:0] source_channel,
	input  logic [3:0] dest_kind,
	input  logic [3:0] dest_channel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       legal,
	output logic [3:0] source_port_count,
	output logic [3:0] dest_port_count
);

	logic      front_valid;
	logic      front_ready;
	ssc_item_t front_item;
	logic      back_valid;
	logic      back_ready;
	ssc_item_t back_item;

	ssc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.device_select (device_select),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.tile_column   (tile_column),
		.tile_row      (tile_row),
		.source_kind   (source_kind),
		.source_channel(source_channel),
		.dest_kind     (dest_kind),
		.dest_channel  (dest_channel),
		.item_valid    (front_valid),
		.item          (front_item),
		.item_ready    (front_ready)
	);

	ssc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_item (front_item),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_item  (back_item)
	);

	ssc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (back_valid),
		.item_ready       (back_ready),
		.item             (back_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.legal            (legal),
		.source_port_count(source_port_count),
		.dest_port_count  (dest_port_count)
	);

endmodule

>>> hw/rtl/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Holds the device register, classifies the tile and looks up both port
// counts, then registers the classified item for the queue.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       device_select,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [5:0] tile_column,
	input  logic [3:0] tile_row,
	input  logic [3:0] source_kind,
	input  logic [3:0] source_channel,
	input  logic [3:0] dest_kind,
	input  logic [3:0] dest_channel,
	output logic       item_valid,
	output ssc_item_t  item,
	input  logic       item_ready
);

	logic        device_select_q;
	logic        valid_s1;
	ssc_item_t   item_s1;
	ssc_item_t   item_d;
	tile_class_t cls_d;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_comb begin
		if (device_select_q == GEN_B && (tile_row == 4'd1 || tile_row == 4'd2)) begin
			cls_d = TILE_MEM;
		end else if (tile_row == 4'd0) begin
			cls_d = TILE_SHIM;
		end else begin
			cls_d = TILE_CORE;
		end
		item_d.gen            = device_select_q;
		item_d.cls            = cls_d;
		item_d.source_kind    = source_kind;
		item_d.source_channel = source_channel;
		item_d.dest_kind      = dest_kind;
		item_d.dest_channel   = dest_channel;
		item_d.source_count   = ssc_port_count(device_select_q, 1'b1, tile_column,
			tile_row, source_kind);
		item_d.dest_count     = ssc_port_count(device_select_q, 1'b0, tile_column,
			tile_row, dest_kind);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_select_q <= GEN_A;
			valid_s1        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				device_select_q <= device_select;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> hw/rtl/ssc_queue.sv
// ----------------------------------------------------------------------------
// ssc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ssc_queue import ssc_pkg::*; #(
	parameter int unsigned DEPTH = SSC_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  ssc_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output ssc_item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ssc_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

>>> hw/rtl/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back
// Applies the range check and the generation's routing rules and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module ssc_back import ssc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  ssc_item_t  item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       legal,
	output logic [3:0] source_port_count,
	output logic [3:0] dest_port_count
);

	localparam logic [15:0] M_CORE  = 16'b1 << K_CORE;
	localparam logic [15:0] M_DMA   = 16'b1 << K_DMA;
	localparam logic [15:0] M_CTRL  = 16'b1 << K_CTRL;
	localparam logic [15:0] M_FIFO  = 16'b1 << K_FIFO;
	localparam logic [15:0] M_SOUTH = 16'b1 << K_SOUTH;
	localparam logic [15:0] M_WEST  = 16'b1 << K_WEST;
	localparam logic [15:0] M_NORTH = 16'b1 << K_NORTH;
	localparam logic [15:0] M_EAST  = 16'b1 << K_EAST;
	localparam logic [15:0] M_SN    = M_SOUTH | M_NORTH;
	localparam logic [15:0] M_FABRIC = M_CTRL | M_FIFO | M_SOUTH | M_WEST |
		M_NORTH | M_EAST;
	// dma channel that memory tiles reserve for control and trace
	localparam logic [3:0] MEM_DMA_CTRL_CHANNEL = 4'd5;

	logic       out_valid_q;
	logic       legal_q;
	logic [3:0] source_count_q;
	logic [3:0] dest_count_q;
	logic       legal_d;

	function automatic logic rules_b(input ssc_item_t it);
		logic [15:0] sb;
		logic [15:0] db;
		logic        same;
		logic        r;
		sb   = 16'b1 << it.source_kind;
		db   = 16'b1 << it.dest_kind;
		same = (it.source_channel == it.dest_channel);
		r    = 1'b0;
		case (it.cls)
			TILE_MEM: begin
				if (it.source_kind == K_DMA) begin
					r = (it.dest_kind == K_DMA) ? same : |(db & (M_CTRL | M_SN));
				end else if (it.source_kind == K_CTRL) begin
					r = (it.dest_kind == K_DMA) ?
						(it.dest_channel == MEM_DMA_CTRL_CHANNEL) : |(db & M_SN);
				end else if (|(sb & M_SN)) begin
					if (|(db & (M_DMA | M_CTRL))) begin
						r = 1'b1;
					end else begin
						r = |(db & M_SN) && same;
					end
				end else if (it.source_kind == K_TRACE) begin
					r = (it.dest_kind == K_DMA) ?
						(it.dest_channel == MEM_DMA_CTRL_CHANNEL) :
						(it.dest_kind == K_SOUTH);
				end
			end
			TILE_SHIM: begin
				if (it.source_kind == K_CTRL) begin
					r = (it.dest_kind != K_CTRL);
				end else if (|(sb & (M_FIFO | M_SOUTH))) begin
					r = |(db & M_FABRIC);
				end else if (|(sb & (M_WEST | M_NORTH | M_EAST))) begin
					r = (it.source_kind == it.dest_kind) ? same : |(db & M_FABRIC);
				end else if (it.source_kind == K_TRACE) begin
					if (|(db & (M_FIFO | M_SOUTH))) begin
						r = 1'b1;
					end else begin
						r = |(db & (M_WEST | M_EAST)) && (it.dest_channel == 4'd0);
					end
				end
			end
			default: begin
				if (|(sb & (M_DMA | M_FIFO | M_SOUTH | M_WEST | M_NORTH | M_EAST)) &&
						|(db & (M_FABRIC | M_CORE | M_DMA))) begin
					r = (it.source_kind == it.dest_kind) ? same : 1'b1;
				end else if (it.source_kind == K_CORE) begin
					r = (it.dest_kind != K_CORE);
				end else if (it.source_kind == K_CTRL) begin
					r = (it.dest_kind != K_CTRL) && (it.dest_kind != K_DMA);
				end else if (it.source_kind == K_TRACE) begin
					r = (it.dest_kind == K_DMA) ? (it.dest_channel == 4'd0) :
						|(db & (M_FIFO | M_SOUTH));
				end
			end
		endcase
		return r;
	endfunction

	always_comb begin
		if (item.source_channel >= item.source_count ||
				item.dest_channel >= item.dest_count) begin
			legal_d = 1'b0;
		end else if (item.gen == GEN_B) begin
			legal_d = rules_b(item);
		end else begin
			legal_d = (item.source_kind == K_TRACE) ? (item.dest_kind == K_SOUTH) : 1'b1;
		end
	end

	assign item_ready        = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign legal             = legal_q;
	assign source_port_count = source_count_q;
	assign dest_port_count   = dest_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			legal_q        <= legal_d;
			source_count_q <= item.source_count;
			dest_count_q   <= item.dest_count;
		end
	end

	a_legal_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && legal_q) |-> (source_count_q != 4'd0 && dest_count_q != 4'd0))
		else $error("legal item with an empty port count");

endmodule
